### hw/rtl/gtta_pkg.sv
// shared types, codes and constants of the gps trip telemetry accumulator
package gtta_pkg;

   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned DIV_CNT_W   = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_DIST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ACCEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_DECEL = 2'd3;

   // milli-unit scale: mm per m, ms per s
   localparam logic [9:0]  MILLI         = 10'd1000;
   // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
   localparam logic [31:0] RECIP_1000    = 32'h10624DD3;
   localparam int unsigned RECIP_SHIFT   = 38;
   localparam logic [19:0] AVG_MAX       = 20'hFFFFF;

   // iteration counts of the shared divider for each use
   localparam logic [DIV_CNT_W-1:0] ACC_ITERS  = 7'd29;
   localparam logic [DIV_CNT_W-1:0] AVG_ITERS  = 7'd20;

   typedef struct packed {
      logic        link_up;
      logic [31:0] fix_tick;
      logic [19:0] speed_kmh;
      logic [18:0] speed_ms;
   } req_word_type;

   typedef struct packed {
      logic [22:0]        trip_distance_m;
      logic signed [31:0] trip_max_speed;
      logic [19:0]        trip_avg_speed;
      logic signed [31:0] trip_max_accel;
      logic signed [31:0] trip_max_decel;
      logic [31:0]        life_distance_m;
      logic signed [31:0] life_max_speed;
      logic signed [31:0] life_max_accel;
      logic signed [31:0] life_max_decel;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP_SPLIT,
      ST_STEP_MUL,
      ST_STEP_RECIP,
      ST_STEP_ADD,
      ST_ACC_GO,
      ST_ACC_WAIT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_TRIP,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_ACC,
      DIV_AVG
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      logic        commit;
      logic        step_split;
      logic        step_mul;
      logic        step_recip;
      logic        div_start;
      div_sel_type div_sel;
      logic        dist_add;
      logic        acc_update;
      logic        avg_fix;
      logic        avg_load;
      logic        trip_mul;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic first;
      logic div_busy;
      logic avg_direct;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/gtta_divider.sv
// shared restoring divider, one quotient bit per cycle
module gtta_divider import gtta_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          rem_init,
   input  logic [63:0]          num_init,
   input  logic [31:0]          den,
   input  logic [DIV_CNT_W-1:0] iters,
   output logic                 busy,
   output logic [63:0]          quo
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [63:0]          num_ff, num_in;
   logic [31:0]          den_ff, den_in;
   logic [32:0]          trial;
   logic [32:0]          diff;
   logic                 ge;

   assign trial = {rem_ff, num_ff[63]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         rem_in  = rem_init;
         num_in  = num_init;
         den_in  = den;
      end else if (busy_ff) begin
         // quotient bits shift in at the bottom as the dividend leaves the top
         rem_in = ge ? diff[31:0] : trial[31:0];
         num_in = {num_ff[62:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = num_ff;

endmodule

### hw/rtl/gtta_datapath.sv
// trip state, baseline registers, arithmetic and result register
module gtta_datapath import gtta_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  req_word_type          req_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   req_word_type       in_ff;
   logic [31:0]        base_dist_ff;
   logic signed [31:0] base_speed_ff, base_accel_ff, base_decel_ff;

   logic [31:0]        prev_tick_ff;
   logic [18:0]        prev_speed_ff;
   logic [31:0]        distance_ff;
   logic signed [31:0] peak_speed_ff, peak_accel_ff, peak_decel_ff;
   logic [63:0]        speed_sum_ff;
   logic [31:0]        count_ff;

   logic [31:0]        step_dt_ff;
   logic [63:0]        dt_recip_ff;
   logic [22:0]        dt_q_ff;
   logic [9:0]         dt_r_ff;
   logic [31:0]        whole_mm_ff;
   logic [28:0]        part_ff;
   logic [63:0]        part_recip_ff;
   logic [28:0]        dv_mag_ff;
   logic [31:0]        dt_mag_ff;
   logic               acc_neg_ff;
   logic [19:0]        avg_ff;
   logic [63:0]        trip_prod_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff;

   logic [31:0]        dt;
   logic [19:0]        dv;
   logic [18:0]        dv_abs;
   logic [22:0]        dt_q;
   logic [31:0]        dt_q_milli;
   logic [31:0]        dt_rem;
   logic [41:0]        whole_prod;
   logic [19:0]        part_mm;
   logic signed [31:0] speed_ext;
   logic signed [31:0] acc;
   logic [28:0]        acc_q;
   logic               avg_sat;
   logic [22:0]        trip_m;
   logic signed [31:0] out_speed, out_accel, out_decel;

   logic [31:0]        div_rem;
   logic [63:0]        div_num;
   logic [31:0]        div_den;
   logic [DIV_CNT_W-1:0] div_iters;
   logic               div_busy;
   logic [63:0]        div_quo;

   assign dt        = in_ff.fix_tick - prev_tick_ff;
   assign dv        = {1'b0, in_ff.speed_ms} - {1'b0, prev_speed_ff};
   assign dv_abs    = dv[19] ? 19'(-dv) : dv[18:0];
   assign speed_ext = signed'({12'd0, in_ff.speed_kmh});
   assign avg_sat   = speed_sum_ff >= {12'd0, count_ff, 20'd0};

   // distance step split as speed * (dt / 1000) + speed * (dt % 1000) / 1000
   assign dt_q       = dt_recip_ff[RECIP_SHIFT+22:RECIP_SHIFT];
   assign dt_q_milli = 32'(dt_q) * 32'(MILLI);
   assign dt_rem     = step_dt_ff - dt_q_milli;
   assign whole_prod = 42'(in_ff.speed_ms) * 42'(dt_q_ff);
   assign part_mm    = part_recip_ff[RECIP_SHIFT+19:RECIP_SHIFT];

   assign acc_q = div_quo[28:0];
   assign acc   = acc_neg_ff ? -signed'({3'd0, acc_q}) : signed'({3'd0, acc_q});

   always_comb begin
      case (cmd.div_sel)
         DIV_ACC: begin
            div_rem   = '0;
            div_num   = {dv_mag_ff, 35'd0};
            div_den   = dt_mag_ff;
            div_iters = ACC_ITERS;
         end
         DIV_AVG: begin
            // mean known to fit 20 bits: upper sum bits are below the count
            div_rem   = speed_sum_ff[51:20];
            div_num   = {speed_sum_ff[19:0], 44'd0};
            div_den   = count_ff;
            div_iters = AVG_ITERS;
         end
         default: begin
            div_rem   = '0;
            div_num   = '0;
            div_den   = count_ff;
            div_iters = AVG_ITERS;
         end
      endcase
   end

   gtta_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .rem_init (div_rem),
      .num_init (div_num),
      .den      (div_den),
      .iters    (div_iters),
      .busy     (div_busy),
      .quo      (div_quo)
   );

   assign status.drop       = !in_ff.link_up || (in_ff.fix_tick == prev_tick_ff);
   assign status.first      = prev_tick_ff == 32'd0;
   assign status.div_busy   = div_busy;
   assign status.avg_direct = (count_ff == 32'd0) || avg_sat;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign trip_m    = trip_prod_ff[RECIP_SHIFT+22:RECIP_SHIFT];
   assign out_speed = (base_speed_ff > peak_speed_ff) ? base_speed_ff : peak_speed_ff;
   assign out_accel = (base_accel_ff > peak_accel_ff) ? base_accel_ff : peak_accel_ff;
   assign out_decel = (base_decel_ff < peak_decel_ff) ? base_decel_ff : peak_decel_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_dist_ff  <= '0;
         base_speed_ff <= '0;
         base_accel_ff <= '0;
         base_decel_ff <= '0;
         prev_tick_ff  <= '0;
         prev_speed_ff <= '0;
         distance_ff   <= '0;
         peak_speed_ff <= '0;
         peak_accel_ff <= '0;
         peak_decel_ff <= '0;
         speed_sum_ff  <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_DIST:  base_dist_ff  <= csr_wdata;
               CSR_BASE_SPEED: base_speed_ff <= signed'(csr_wdata);
               CSR_BASE_ACCEL: base_accel_ff <= signed'(csr_wdata);
               CSR_BASE_DECEL: base_decel_ff <= signed'(csr_wdata);
               default: ;
            endcase
         end
         if (cmd.commit) begin
            prev_tick_ff  <= in_ff.fix_tick;
            prev_speed_ff <= in_ff.speed_ms;
            speed_sum_ff  <= speed_sum_ff + {44'd0, in_ff.speed_kmh};
            count_ff      <= count_ff + 32'd1;
            if (speed_ext > peak_speed_ff) begin
               peak_speed_ff <= speed_ext;
            end
         end
         if (cmd.dist_add) begin
            distance_ff <= distance_ff + whole_mm_ff + {12'd0, part_mm};
         end
         if (cmd.acc_update) begin
            if (acc > peak_accel_ff) begin
               peak_accel_ff <= acc;
            end
            if (acc < peak_decel_ff) begin
               peak_decel_ff <= acc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_data;
      end
      if (cmd.commit) begin
         step_dt_ff   <= dt;
         dt_recip_ff  <= 64'(dt) * 64'(RECIP_1000);
         dv_mag_ff    <= 29'(dv_abs) * 29'(MILLI);
         dt_mag_ff    <= dt[31] ? -dt : dt;
         acc_neg_ff   <= dv[19] ^ dt[31];
      end
      if (cmd.step_split) begin
         dt_q_ff <= dt_q;
         dt_r_ff <= dt_rem[9:0];
      end
      if (cmd.step_mul) begin
         whole_mm_ff <= whole_prod[31:0];
         part_ff     <= 29'(in_ff.speed_ms) * 29'(dt_r_ff);
      end
      if (cmd.step_recip) begin
         part_recip_ff <= 64'(part_ff) * 64'(RECIP_1000);
      end
      if (cmd.avg_fix) begin
         avg_ff <= (count_ff == 32'd0) ? 20'd0 : AVG_MAX;
      end else if (cmd.avg_load) begin
         avg_ff <= div_quo[19:0];
      end
      if (cmd.trip_mul) begin
         trip_prod_ff <= 64'(distance_ff) * 64'(RECIP_1000);
      end
      if (cmd.out_load) begin
         rsp_ff.trip_distance_m <= trip_m;
         rsp_ff.trip_max_speed  <= peak_speed_ff;
         rsp_ff.trip_avg_speed  <= avg_ff;
         rsp_ff.trip_max_accel  <= peak_accel_ff;
         rsp_ff.trip_max_decel  <= peak_decel_ff;
         rsp_ff.life_distance_m <= base_dist_ff + {9'd0, trip_m};
         rsp_ff.life_max_speed  <= out_speed;
         rsp_ff.life_max_accel  <= out_accel;
         rsp_ff.life_max_decel  <= out_decel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/gtta_control.sv
// sequencer that steps one fix through the datapath
module gtta_control import gtta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.drop) begin
               state_in = ST_IDLE;
            end else if (status.first) begin
               state_in = ST_AVG_GO;
            end else begin
               state_in = ST_STEP_SPLIT;
            end
         end
         ST_STEP_SPLIT: state_in = ST_STEP_MUL;
         ST_STEP_MUL:   state_in = ST_STEP_RECIP;
         ST_STEP_RECIP: state_in = ST_STEP_ADD;
         ST_STEP_ADD:   state_in = ST_ACC_GO;
         ST_ACC_GO:     state_in = ST_ACC_WAIT;
         ST_ACC_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            if (status.avg_direct) begin
               state_in = ST_TRIP;
            end else begin
               state_in = ST_AVG_WAIT;
            end
         end
         ST_AVG_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_TRIP;
            end
         end
         ST_TRIP:      state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.div_sel = DIV_ACC;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CHECK: begin
            cmd.commit = !status.drop;
         end
         ST_STEP_SPLIT: begin
            cmd.step_split = 1'b1;
         end
         ST_STEP_MUL: begin
            cmd.step_mul = 1'b1;
         end
         ST_STEP_RECIP: begin
            cmd.step_recip = 1'b1;
         end
         ST_STEP_ADD: begin
            cmd.dist_add = 1'b1;
         end
         ST_ACC_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ACC;
         end
         ST_ACC_WAIT: begin
            cmd.acc_update = !status.div_busy;
         end
         ST_AVG_GO: begin
            cmd.div_sel   = DIV_AVG;
            cmd.avg_fix   = status.avg_direct;
            cmd.div_start = !status.avg_direct;
         end
         ST_AVG_WAIT: begin
            cmd.avg_load = !status.div_busy;
         end
         ST_TRIP: begin
            cmd.trip_mul = 1'b1;
         end
         ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/gps_trip_telemetry_accumulator_unit.sv
// top level of the gps trip telemetry accumulator
// Takes one fix word at a time and, unless the link is down or the tick repeats the last
// processed tick, returns one word of session and lifetime statistics. A fix is taken only
// while the unit is idle; a dropped fix frees it again from the check state. A kept fix
// skips the mean division when the mean saturates or the count wrapped; a first fix skips
// distance and acceleration. One shared bit-serial divider runs over 29 quotient bits
// for the acceleration and 20 for the mean; the distance step is split by reciprocal
// multiplication over the split, multiply, reciprocal and add steps. The result waits in
// an output register, and the next fix can be taken while it does; a result that is still
// waiting when the next one is done holds the unit until it is taken. Baseline registers
// are to be written through the csr port while idle, which the block does not enforce.
module gps_trip_telemetry_accumulator_unit import gtta_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   gtta_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gtta_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

### tb/gps_trip_telemetry_accumulator_unit_tb.sv
// self-checking testbench of the gps trip telemetry accumulator: opening fixes, then random trips
module gps_trip_telemetry_accumulator_unit_tb;
   import gtta_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 150;

   typedef struct {
      req_word_type fix;
      bit           typed;
      rsp_word_type word;
   } opening_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // baselines as last written
   logic [31:0]        base_dist_m = '0;
   logic signed [31:0] base_kmh = '0;
   logic signed [31:0] base_acc = '0;
   logic signed [31:0] base_dec = '0;

   // session state of the predictor
   logic [31:0]        last_tick = '0;
   logic [31:0]        last_speed_ms = '0;
   logic [31:0]        odo_mm = '0;
   logic signed [31:0] peak_kmh = '0;
   logic signed [31:0] peak_acc = '0;
   logic signed [31:0] peak_dec = '0;
   logic [63:0]        kmh_sum = '0;
   logic [31:0]        fix_count = '0;

   rsp_word_type    stats_due[$];
   opening_row_type opening_fixes[$];
   logic [31:0]     trip_tick = '0;
   bit              idle_on = 1'b1;
   int unsigned     stall_left = 0;
   int unsigned     mismatches = 0;

   gps_trip_telemetry_accumulator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_word_type fix_word(input logic link, input logic [31:0] tick,
                                             input logic [19:0] kmh, input logic [18:0] ms);
      req_word_type w;
      w.link_up   = link;
      w.fix_tick  = tick;
      w.speed_kmh = kmh;
      w.speed_ms  = ms;
      return w;
   endfunction

   // trip statistics after one fix; kept is low when the fix is dropped
   task automatic predict_fix(input req_word_type fix, output bit kept, output rsp_word_type r);
      logic [31:0]        dt;
      logic [63:0]        stride;
      longint             cur_v;
      longint             prev_v;
      longint             den;
      longint             acc_wide;
      logic signed [31:0] acc;
      logic signed [31:0] kmh;
      logic [63:0]        mean;
      logic [31:0]        trip_m;
      kept = 1'b0;
      r = '0;
      if (!fix.link_up || fix.fix_tick == last_tick) return;
      kept = 1'b1;
      if (last_tick != 0) begin
         dt = fix.fix_tick - last_tick;
         stride = (64'(fix.speed_ms) * 64'(dt)) / 64'd1000;
         odo_mm = odo_mm + stride[31:0];
         cur_v = longint'(fix.speed_ms);
         prev_v = longint'(last_speed_ms);
         // divisor is the tick step read as signed
         den = longint'($signed(dt));
         acc_wide = ((cur_v - prev_v) * 1000) / den;
         acc = acc_wide[31:0];
         if (acc > peak_acc) peak_acc = acc;
         if (acc < peak_dec) peak_dec = acc;
      end
      kmh = {12'b0, fix.speed_kmh};
      if (kmh > peak_kmh) peak_kmh = kmh;
      kmh_sum = kmh_sum + 64'(fix.speed_kmh);
      fix_count = fix_count + 32'd1;
      if (fix_count == 0) begin
         mean = '0;
      end else begin
         mean = kmh_sum / 64'(fix_count);
         if (mean > 64'(AVG_MAX)) mean = 64'(AVG_MAX);
      end
      trip_m = odo_mm / 32'd1000;
      r.trip_distance_m = trip_m[22:0];
      r.trip_max_speed  = peak_kmh;
      r.trip_avg_speed  = mean[19:0];
      r.trip_max_accel  = peak_acc;
      r.trip_max_decel  = peak_dec;
      r.life_distance_m = base_dist_m + trip_m;
      r.life_max_speed  = (base_kmh > peak_kmh) ? base_kmh : peak_kmh;
      r.life_max_accel  = (base_acc > peak_acc) ? base_acc : peak_acc;
      r.life_max_decel  = (base_dec < peak_dec) ? base_dec : peak_dec;
      last_tick = fix.fix_tick;
      last_speed_ms = 32'(fix.speed_ms);
   endtask

   task automatic send_fix(input req_word_type fix, input bit typed,
                           input rsp_word_type typed_word, output bit kept);
      rsp_word_type want;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= fix;
      do @(posedge clock); while (!req_ready);
      predict_fix(fix, kept, want);
      if (kept) stats_due.push_back(typed ? typed_word : want);
   endtask

   // drain all pending words, then give a dropped fix time to clear
   task automatic settle();
      req_valid <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_BASE_DIST:  base_dist_m = value;
         CSR_BASE_SPEED: base_kmh = value;
         CSR_BASE_ACCEL: base_acc = value;
         CSR_BASE_DECEL: base_dec = value;
         default: ;
      endcase
   endtask

   task automatic set_baselines(input logic [3:0] sel, input logic [31:0] distance,
                                input logic [31:0] speed, input logic [31:0] accel,
                                input logic [31:0] decel);
      if (sel[0]) put_reg(CSR_BASE_DIST, distance);
      if (sel[1]) put_reg(CSR_BASE_SPEED, speed);
      if (sel[2]) put_reg(CSR_BASE_ACCEL, accel);
      if (sel[3]) put_reg(CSR_BASE_DECEL, decel);
      csr_we <= 1'b0;
   endtask

   // mostly steady fixes with rising ticks, with drops, restarts and odd gaps mixed in
   task automatic drive_trip(input int unsigned kept_goal);
      int unsigned  done;
      int unsigned  pick;
      req_word_type fix;
      bit           kept;
      done = 0;
      while (done < kept_goal) begin
         pick = $urandom_range(0, 99);
         fix.link_up = 1'b1;
         fix.speed_kmh = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                     : 20'($urandom_range(0, 1000000));
         fix.speed_ms = ($urandom_range(0, 7) == 0) ? 19'($urandom)
                                                    : 19'($urandom_range(0, 300000));
         if (pick < 80)
            trip_tick = trip_tick + $urandom_range(1, 2000);
         else if (pick < 85)
            fix.link_up = 1'b0;
         else if (pick < 90)
            ; // same tick again
         else if (pick < 93)
            trip_tick = '0;
         else if (pick < 96)
            trip_tick = $urandom;
         else if (pick < 98)
            trip_tick = 32'hFFFF_FFFF - $urandom_range(0, 3);
         else
            trip_tick = trip_tick + 32'h8000_0000 + $urandom_range(0, 1000);
         fix.fix_tick = fix.link_up ? trip_tick : 32'($urandom);
         send_fix(fix, 1'b0, '0, kept);
         if (kept) done++;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (stats_due.size() == 0) begin
            $error("result word with no fix pending");
            mismatches++;
         end else begin
            want = stats_due.pop_front();
            check_field("trip_distance_m", 32'(want.trip_distance_m),
                        32'(rsp_data.trip_distance_m));
            check_field("trip_max_speed", want.trip_max_speed, rsp_data.trip_max_speed);
            check_field("trip_avg_speed", 32'(want.trip_avg_speed),
                        32'(rsp_data.trip_avg_speed));
            check_field("trip_max_accel", want.trip_max_accel, rsp_data.trip_max_accel);
            check_field("trip_max_decel", want.trip_max_decel, rsp_data.trip_max_decel);
            check_field("life_distance_m", want.life_distance_m, rsp_data.life_distance_m);
            check_field("life_max_speed", want.life_max_speed, rsp_data.life_max_speed);
            check_field("life_max_accel", want.life_max_accel, rsp_data.life_max_accel);
            check_field("life_max_decel", want.life_max_decel, rsp_data.life_max_decel);
         end
      end
   end

   initial begin
      rsp_word_type full_swing;
      bit           kept;
      // 1 s at full speed straight after a standing fix
      full_swing = '{trip_distance_m: 23'd524, trip_max_speed: 32'sd1048575,
                     trip_avg_speed: 20'd524287, trip_max_accel: 32'sd524287,
                     trip_max_decel: 32'sd0, life_distance_m: 32'd524,
                     life_max_speed: 32'sd1048575, life_max_accel: 32'sd524287,
                     life_max_decel: 32'sd0};
      // link down
      opening_fixes.push_back('{fix_word(1'b0, 32'd5, 20'hFFFFF, 19'h7FFFF), 1'b0, '0});
      // tick zero right after reset repeats the reset tick
      opening_fixes.push_back('{fix_word(1'b1, 32'd0, 20'd1234, 19'd567), 1'b0, '0});
      // first fix, standing still
      opening_fixes.push_back('{fix_word(1'b1, 32'd1000, 20'd0, 19'd0), 1'b1, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'd1000, 20'd500000, 19'd1000), 1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'd2000, 20'hFFFFF, 19'h7FFFF), 1'b1,
                                full_swing});
      // hard stop over one ms
      opening_fixes.push_back('{fix_word(1'b1, 32'd2001, 20'd0, 19'd0), 1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b0, 32'd3000, 20'd0, 19'd0), 1'b0, '0});
      // tick zero after a fix: distance wraps, next fix counts as first
      opening_fixes.push_back('{fix_word(1'b1, 32'd0, 20'd1000, 19'd1000), 1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'd0, 20'd2000, 19'd2000), 1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'd500, 20'd250000, 19'd69444), 1'b0, '0});
      // gap of 2^31 ms and more: negative divisor
      opening_fixes.push_back('{fix_word(1'b1, 32'h8000_01F4, 20'd1000000, 19'd300000),
                                1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'hFFFF_FFF0, 20'd0, 19'd0), 1'b0, '0});
      // tick wraps through zero
      opening_fixes.push_back('{fix_word(1'b1, 32'h0000_0010, 20'd120000, 19'd33333),
                                1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'hFFFF_FFFF, 20'd1000000, 19'd300000),
                                1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'hFFFF_FFFE, 20'd1, 19'd1), 1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'h7FFF_FFFF, 20'hAAAAA, 19'h55555),
                                1'b0, '0});
      opening_fixes.push_back('{fix_word(1'b1, 32'h8000_0000, 20'h55555, 19'h2AAAA),
                                1'b0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_fixes[i])
         send_fix(opening_fixes[i].fix, opening_fixes[i].typed, opening_fixes[i].word, kept);
      settle();

      set_baselines(4'b1111, $urandom, $urandom, $urandom, $urandom);
      drive_trip(360);
      settle();

      set_baselines(4'b1111, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      drive_trip(320);
      settle();

      set_baselines(4'b1111, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      drive_trip(320);
      settle();

      // baselines near the session peaks so the lifetime picks go both ways
      set_baselines(4'b0110, 32'h0, $urandom_range(0, 1000000),
                    $urandom_range(0, 300000000), 32'h0);
      drive_trip(360);
      settle();

      set_baselines(4'b1001, $urandom, 32'h0, 32'h0, 32'h0 - $urandom_range(0, 300000000));
      idle_on <= 1'b0;
      drive_trip(400);
      settle();

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
hw/rtl/gtta_pkg.sv
hw/rtl/gtta_divider.sv
hw/rtl/gtta_datapath.sv
hw/rtl/gtta_control.sv
hw/rtl/gps_trip_telemetry_accumulator_unit.sv
tb/gps_trip_telemetry_accumulator_unit_tb.sv
